/* sv/iac_pkg.sv */
// iac_pkg: shared widths, constants, register codes and stage types of the
// intrusion alarm controller. Used by the channel interfaces and all modules.
package iac_pkg;

  localparam int LEVEL_W = 10;
  localparam int ECHO_W  = 20;
  localparam int TIME_W  = 32;
  localparam int DIST_W  = 15;
  localparam int SECS_W  = 23;

  localparam int MTHR_W  = 10;
  localparam int NTHR_W  = 9;
  localparam int HOLD_W  = 16;
  localparam int LAMP_W  = 8;
  localparam int AMAX_W  = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // distance = (echo_us * 1114) >> 16, fixed-point form of echo / 58.824
  localparam int DIST_MUL_W = 11;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = 11'd1114;
  localparam int DIST_SHIFT = 16;
  localparam int DIST_PROD_W = ECHO_W + DIST_MUL_W;

  localparam int MS_PER_S = 1000;

  // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam int RECIP_W = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_PROD_W = TIME_W + RECIP_W;

  localparam logic [MTHR_W-1:0] MTHR_RST = 10'd100;
  localparam logic [NTHR_W-1:0] NTHR_RST = 9'd50;
  localparam logic [HOLD_W-1:0] HOLD_RST = 16'd2000;
  localparam logic [LAMP_W-1:0] LAMP_RST = 8'd5;
  localparam logic [AMAX_W-1:0] AMAX_RST = 12'd180;

  // whole seconds exceed L exactly when elapsed ms >= (L + 1) * 1000
  localparam logic [TIME_W-1:0] LAMP_LIM_RST = TIME_W'((5 + 1) * MS_PER_S);
  localparam logic [TIME_W-1:0] AMAX_LIM_RST = TIME_W'((180 + 1) * MS_PER_S);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_MOTION_THR  = 3'd1,
    REG_NEAR_THR    = 3'd2,
    REG_HOLD_MS     = 3'd3,
    REG_LAMP_OFF_S  = 3'd4,
    REG_ALARM_MAX_S = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              enable;
    logic [MTHR_W-1:0] motion_thr;
    logic [NTHR_W-1:0] near_thr;
    logic [HOLD_W-1:0] hold_ms;
    logic [TIME_W-1:0] lamp_lim;
    logic [TIME_W-1:0] amax_lim;
    logic              go_idle;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DIST_W-1:0]  dist_cm;
    logic [TIME_W-1:0]  now;
  } upd_t;

  typedef struct packed {
    logic              alarm;
    logic              bell;
    logic              shock;
    logic              lamp;
    logic [DIST_W-1:0] dist_cm;
    logic [TIME_W-1:0] elapsed;
  } stat_t;

endpackage

/* sv/iac_in_if.sv */
// iac_in_if: update channel, valid/ready with sensor reading, echo width
// and timestamp. Depends on iac_pkg.
interface iac_in_if import iac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] motion_level;
  logic [ECHO_W-1:0]  echo_us;
  logic [TIME_W-1:0]  now_ms;

  modport source(output valid, output motion_level, output echo_us, output now_ms,
                 input ready);
  modport sink(input valid, input motion_level, input echo_us, input now_ms,
               output ready);
endinterface

/* sv/iac_out_if.sv */
// iac_out_if: result channel, valid/ready with alarm drive states, distance
// and alarm seconds. Depends on iac_pkg.
interface iac_out_if import iac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              alarm_active;
  logic              bell_on;
  logic              shock_on;
  logic              lamp_on;
  logic [DIST_W-1:0] distance_cm;
  logic [SECS_W-1:0] alarm_seconds;

  modport source(output valid, output alarm_active, output bell_on, output shock_on,
                 output lamp_on, output distance_cm, output alarm_seconds,
                 input ready);
  modport sink(input valid, input alarm_active, input bell_on, input shock_on,
               input lamp_on, input distance_cm, input alarm_seconds,
               output ready);
endinterface

/* sv/iac_cfg_if.sv */
// iac_cfg_if: configuration write channel, valid/ready with register index
// and write data. Depends on iac_pkg.
interface iac_cfg_if import iac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/iac_cfg_regs.sv */
// iac_cfg_regs: configuration register file and precomputed time limits.
// Depends on iac_pkg and iac_cfg_if.
module iac_cfg_regs import iac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  iac_cfg_if.sink   cfg_if,
  output cfg_t      cfg
);

  logic              enable_r;
  logic [MTHR_W-1:0] motion_thr_r;
  logic [NTHR_W-1:0] near_thr_r;
  logic [HOLD_W-1:0] hold_r;
  logic [LAMP_W-1:0] lamp_off_r;
  logic [AMAX_W-1:0] alarm_max_r;
  logic [TIME_W-1:0] lamp_lim_r;
  logic [TIME_W-1:0] amax_lim_r;
  logic [TIME_W-1:0] lamp_lim_nxt;
  logic [TIME_W-1:0] amax_lim_nxt;
  logic              wr;

  assign cfg_if.ready = 1'b1;
  assign wr = cfg_if.valid;

  assign lamp_lim_nxt = (TIME_W'(lamp_off_r) + TIME_W'(1)) * TIME_W'(MS_PER_S);
  assign amax_lim_nxt = (TIME_W'(alarm_max_r) + TIME_W'(1)) * TIME_W'(MS_PER_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      motion_thr_r <= MTHR_RST;
      near_thr_r   <= NTHR_RST;
      hold_r       <= HOLD_RST;
      lamp_off_r   <= LAMP_RST;
      alarm_max_r  <= AMAX_RST;
      lamp_lim_r   <= LAMP_LIM_RST;
      amax_lim_r   <= AMAX_LIM_RST;
    end else begin
      lamp_lim_r <= lamp_lim_nxt;
      amax_lim_r <= amax_lim_nxt;
      if (wr) begin
        case (cfg_reg_t'(cfg_if.index))
          REG_ENABLE:      enable_r     <= cfg_if.data[0];
          REG_MOTION_THR:  motion_thr_r <= cfg_if.data[MTHR_W-1:0];
          REG_NEAR_THR:    near_thr_r   <= cfg_if.data[NTHR_W-1:0];
          REG_HOLD_MS:     hold_r       <= cfg_if.data[HOLD_W-1:0];
          REG_LAMP_OFF_S:  lamp_off_r   <= cfg_if.data[LAMP_W-1:0];
          REG_ALARM_MAX_S: alarm_max_r  <= cfg_if.data[AMAX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.enable     = enable_r;
    cfg.motion_thr = motion_thr_r;
    cfg.near_thr   = near_thr_r;
    cfg.hold_ms    = hold_r;
    cfg.lamp_lim   = lamp_lim_r;
    cfg.amax_lim   = amax_lim_r;
    // every write of zero to enable drops the alarm outputs to idle
    cfg.go_idle    = wr && (cfg_if.index == REG_ENABLE) && !cfg_if.data[0];
  end

endmodule

/* sv/iac_core.sv */
// iac_core: input register with distance scaling, then the per-update state
// machine of flags, stamps and drive states feeding a status register.
// Depends on iac_pkg and iac_in_if.
module iac_core import iac_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  iac_in_if.sink  in_if,
  input  cfg_t    cfg,
  output stat_t   stat,
  output logic    stat_valid,
  input  logic    stat_take
);

  upd_t              s1_r;
  logic              s1_valid_r;
  stat_t             s2_r;
  logic              s2_valid_r;
  stat_t             s2_nxt;
  logic              s1_adv;
  logic              s2_free;
  logic              acc;
  logic [DIST_PROD_W-1:0] dist_prod;

  logic              motion_r, motion_nxt;
  logic [TIME_W-1:0] mstamp_r, mstamp_nxt;
  logic              near_r, near_nxt;
  logic [TIME_W-1:0] nstamp_r, nstamp_nxt;
  logic              alarm_r, alarm_nxt;
  logic [TIME_W-1:0] astamp_r, astamp_nxt;
  logic              shock_r, shock_nxt;
  logic              bell_r, bell_nxt;
  logic              lamp_r, lamp_nxt;
  logic [TIME_W-1:0] el_m;
  logic [TIME_W-1:0] el_n;
  logic [TIME_W-1:0] el_a;

  assign s2_free      = !s2_valid_r || stat_take;
  assign s1_adv       = s1_valid_r && s2_free;
  assign in_if.ready  = !s1_valid_r || s2_free;
  assign acc          = in_if.valid && in_if.ready;
  assign dist_prod    = DIST_PROD_W'(in_if.echo_us) * DIST_PROD_W'(DIST_MUL);

  assign el_m = s1_r.now - mstamp_r;
  assign el_n = s1_r.now - nstamp_r;

  always_comb begin
    motion_nxt = motion_r;
    mstamp_nxt = mstamp_r;
    near_nxt   = near_r;
    nstamp_nxt = nstamp_r;
    alarm_nxt  = alarm_r;
    astamp_nxt = astamp_r;
    shock_nxt  = shock_r;
    bell_nxt   = bell_r;
    lamp_nxt   = lamp_r;
    el_a       = s1_r.now - astamp_r;

    if (s1_adv && cfg.enable) begin
      if (s1_r.level > cfg.motion_thr) begin
        motion_nxt = 1'b1;
        mstamp_nxt = s1_r.now;
      end else if (el_m > TIME_W'(cfg.hold_ms)) begin
        motion_nxt = 1'b0;
      end

      if (s1_r.dist_cm < DIST_W'(cfg.near_thr)) begin
        near_nxt   = 1'b1;
        nstamp_nxt = s1_r.now;
      end else if (el_n > TIME_W'(cfg.hold_ms)) begin
        near_nxt = 1'b0;
      end

      // both detections present: latch and restart the alarm clock
      if (motion_nxt && near_nxt) begin
        alarm_nxt  = 1'b1;
        astamp_nxt = s1_r.now;
      end
      el_a = s1_r.now - astamp_nxt;

      if (alarm_nxt) begin
        bell_nxt  = 1'b1;
        shock_nxt = !shock_r;
        if (el_a >= cfg.lamp_lim) begin
          lamp_nxt = 1'b0;
        end
        if (el_a >= cfg.amax_lim) begin
          alarm_nxt = 1'b0;
          bell_nxt  = 1'b0;
          lamp_nxt  = 1'b1;
          shock_nxt = 1'b0;
        end
      end
    end

    if (cfg.go_idle) begin
      alarm_nxt = 1'b0;
      bell_nxt  = 1'b0;
      lamp_nxt  = 1'b1;
      shock_nxt = 1'b0;
    end

    s2_nxt.alarm   = alarm_nxt;
    s2_nxt.bell    = bell_nxt;
    s2_nxt.shock   = shock_nxt;
    s2_nxt.lamp    = lamp_nxt;
    s2_nxt.dist_cm = s1_r.dist_cm;
    s2_nxt.elapsed = el_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      motion_r   <= 1'b0;
      mstamp_r   <= '0;
      near_r     <= 1'b0;
      nstamp_r   <= '0;
      alarm_r    <= 1'b0;
      astamp_r   <= '0;
      shock_r    <= 1'b0;
      bell_r     <= 1'b0;
      lamp_r     <= 1'b1;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      motion_r <= motion_nxt;
      mstamp_r <= mstamp_nxt;
      near_r   <= near_nxt;
      nstamp_r <= nstamp_nxt;
      alarm_r  <= alarm_nxt;
      astamp_r <= astamp_nxt;
      shock_r  <= shock_nxt;
      bell_r   <= bell_nxt;
      lamp_r   <= lamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.level   <= in_if.motion_level;
      s1_r.dist_cm <= dist_prod[DIST_SHIFT +: DIST_W];
      s1_r.now     <= in_if.now_ms;
    end
    if (s1_adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign stat       = s2_r;
  assign stat_valid = s2_valid_r;

endmodule

/* sv/iac_sec_div.sv */
// iac_sec_div: output register stage, turns elapsed alarm milliseconds into
// whole seconds by reciprocal multiply. Depends on iac_pkg and iac_out_if.
module iac_sec_div import iac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  stat_t     stat,
  input  logic      stat_valid,
  output logic      stat_take,
  iac_out_if.source out_if
);

  logic                    out_valid_r;
  logic                    alarm_r;
  logic                    bell_r;
  logic                    shock_r;
  logic                    lamp_r;
  logic [DIST_W-1:0]       dist_r;
  logic [SECS_W-1:0]       secs_r;
  logic [RECIP_PROD_W-1:0] prod;
  logic [SECS_W-1:0]       secs_nxt;

  assign stat_take = stat_valid && (!out_valid_r || out_if.ready);
  assign prod      = RECIP_PROD_W'(stat.elapsed) * RECIP_PROD_W'(RECIP_1000);
  assign secs_nxt  = stat.alarm ? prod[RECIP_SHIFT +: SECS_W] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_if.ready) begin
      out_valid_r <= stat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stat_take) begin
      alarm_r <= stat.alarm;
      bell_r  <= stat.bell;
      shock_r <= stat.shock;
      lamp_r  <= stat.lamp;
      dist_r  <= stat.dist_cm;
      secs_r  <= secs_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.alarm_active  = alarm_r;
  assign out_if.bell_on       = bell_r;
  assign out_if.shock_on      = shock_r;
  assign out_if.lamp_on       = lamp_r;
  assign out_if.distance_cm   = dist_r;
  assign out_if.alarm_seconds = secs_r;

endmodule

/* sv/intrusion_alarm_controller.sv */
// Intrusion alarm controller: takes one sensor update per clock unless stalled
// and returns one result word per update, valid on the result port once the
// accepted word has passed the input register with distance scaling, state update
// and seconds divide into the output register. Motion, near and alarm state lives
// in one register loop that closes every cycle, so back-to-back updates run at
// full rate; any stage moves forward as soon as the stage after it has room, so
// a stalled result does not block new updates until all three stages are full.
// Configuration writes are taken every cycle; new lamp and alarm time limits
// apply behind the setting and limit registers. No clearing pass after reset.
module intrusion_alarm_controller import iac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  iac_in_if.sink    in_if,
  iac_out_if.source out_if,
  iac_cfg_if.sink   cfg_if
);

  cfg_t  cfg;
  stat_t stat;
  logic  stat_valid;
  logic  stat_take;

  iac_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  iac_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg        (cfg),
    .stat       (stat),
    .stat_valid (stat_valid),
    .stat_take  (stat_take)
  );

  iac_sec_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .stat_valid (stat_valid),
    .stat_take  (stat_take),
    .out_if     (out_if)
  );

  // a latched alarm always rings the bell
  a_bell_with_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.alarm_active |-> out_if.bell_on)
    else $error("alarm active without bell");

  // seconds count only while latched
  a_secs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.alarm_active |-> out_if.alarm_seconds == '0)
    else $error("alarm seconds nonzero while idle");

  // lamp is dark only during an alarm
  a_lamp_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.lamp_on |-> out_if.alarm_active)
    else $error("lamp off without alarm");

endmodule
